// File: design/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

    localparam int COORD_BITS = 16;

    // Coordinate differences are taken at least 17 bits wide so that they can be
    // clamped to the 16-bit magnitude that the squaring uses.
    localparam int DIFF_BITS = (COORD_BITS + 1 > 17) ? COORD_BITS + 1 : 17;
    localparam int MAG_BITS  = 16;
    localparam int SQ_BITS   = 2 * MAG_BITS + 1;

    localparam int TIMEOUT_BITS = 20;
    localparam int DIST_BITS    = 15;
    localparam int TIME_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = TIMEOUT_BITS;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(8000);
    localparam logic [DIST_BITS-1:0]    MOVE_RESET    = DIST_BITS'(150);
    localparam logic [DIST_BITS-1:0]    RELEASE_RESET = DIST_BITS'(500);

    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MOVE    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = CFG_IDX_BITS'(2);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_HALT   = 1'b1;

    typedef struct packed {
        logic [TIMEOUT_BITS-1:0] timeout;
        logic [DIST_BITS-1:0]    move;
        logic [DIST_BITS-1:0]    release_dist;
    } t_cfg;

    typedef struct packed {
        logic                         operation;
        logic                         pose_valid;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]         time_ms;
    } t_item;

endpackage

`default_nettype wire

// File: design/msd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module msd_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [msd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [msd_pkg::CFG_DAT_BITS-1:0]    i_cfg_data,
    output msd_pkg::t_cfg                            o_cfg
);
    import msd_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout      <= TIMEOUT_RESET;
            r_cfg.move         <= MOVE_RESET;
            r_cfg.release_dist <= RELEASE_RESET;
        end else if (i_cfg_valid) begin
            // Writes to an index beyond the register list are dropped.
            unique case (i_cfg_index)
                REG_TIMEOUT: r_cfg.timeout      <= i_cfg_data[TIMEOUT_BITS-1:0];
                REG_MOVE:    r_cfg.move         <= i_cfg_data[DIST_BITS-1:0];
                REG_RELEASE: r_cfg.release_dist <= i_cfg_data[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/msd_beyond.sv
`timescale 1ns / 1ps
`default_nettype none

module msd_beyond (
    input  wire logic signed [msd_pkg::COORD_BITS-1:0] i_ax,
    input  wire logic signed [msd_pkg::COORD_BITS-1:0] i_ay,
    input  wire logic signed [msd_pkg::COORD_BITS-1:0] i_bx,
    input  wire logic signed [msd_pkg::COORD_BITS-1:0] i_by,
    input  wire logic [msd_pkg::DIST_BITS-1:0]         i_limit,
    output logic                                       o_beyond
);
    import msd_pkg::*;

    localparam logic [DIFF_BITS-1:0] MAG_MAX = DIFF_BITS'((1 << MAG_BITS) - 1);

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic [DIFF_BITS-1:0]        ax_abs;
    logic [DIFF_BITS-1:0]        ay_abs;
    logic [MAG_BITS-1:0]         mx;
    logic [MAG_BITS-1:0]         my;
    logic [SQ_BITS-1:0]          d2;
    logic [SQ_BITS-1:0]          l2;

    always_comb begin
        dx     = DIFF_BITS'(i_ax) - DIFF_BITS'(i_bx);
        dy     = DIFF_BITS'(i_ay) - DIFF_BITS'(i_by);
        ax_abs = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        ay_abs = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
        // A difference past the 16-bit range already exceeds any 15-bit limit.
        mx     = (ax_abs > MAG_MAX) ? MAG_MAX[MAG_BITS-1:0] : ax_abs[MAG_BITS-1:0];
        my     = (ay_abs > MAG_MAX) ? MAG_MAX[MAG_BITS-1:0] : ay_abs[MAG_BITS-1:0];
        d2     = SQ_BITS'(mx) * SQ_BITS'(mx) + SQ_BITS'(my) * SQ_BITS'(my);
        l2     = SQ_BITS'(i_limit) * SQ_BITS'(i_limit);
        o_beyond = d2 > l2;
    end

endmodule

`default_nettype wire

// File: design/msd_track.sv
`timescale 1ns / 1ps
`default_nettype none

module msd_track (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_update,
    input  msd_pkg::t_item       i_item,
    input  msd_pkg::t_cfg        i_cfg,
    output logic                 o_stuck
);
    import msd_pkg::*;

    logic                         r_started;
    logic                         r_latched;
    logic signed [COORD_BITS-1:0] r_ref_x;
    logic signed [COORD_BITS-1:0] r_ref_y;
    logic [TIME_BITS-1:0]         r_ref_time;
    logic signed [COORD_BITS-1:0] r_stall_x;
    logic signed [COORD_BITS-1:0] r_stall_y;

    logic                         n_started;
    logic                         n_latched;
    logic                         set_ref;
    logic                         set_stall;

    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [DIST_BITS-1:0]         limit;
    logic                         far;
    logic [TIME_BITS-1:0]         elapsed;

    // One distance unit serves both tests: release while latched, movement otherwise.
    assign center_x = r_latched ? r_stall_x : r_ref_x;
    assign center_y = r_latched ? r_stall_y : r_ref_y;
    assign limit    = r_latched ? i_cfg.release_dist : i_cfg.move;
    assign elapsed  = i_item.time_ms - r_ref_time;

    msd_beyond u_beyond (
        .i_ax     (i_item.pos_x),
        .i_ay     (i_item.pos_y),
        .i_bx     (center_x),
        .i_by     (center_y),
        .i_limit  (limit),
        .o_beyond (far)
    );

    always_comb begin
        n_started = r_started;
        n_latched = r_latched;
        set_ref   = 1'b0;
        set_stall = 1'b0;
        o_stuck   = 1'b0;
        if (i_item.operation == OP_HALT) begin
            n_started = 1'b0;
            n_latched = 1'b0;
        end else if (i_item.pose_valid) begin
            if (!r_started) begin
                n_started = 1'b1;
                set_ref   = 1'b1;
            end else if (r_latched) begin
                if (far) begin
                    n_latched = 1'b0;
                    set_ref   = 1'b1;
                end else begin
                    o_stuck = 1'b1;
                end
            end else if (far) begin
                set_ref = 1'b1;
            end else if (elapsed >= TIME_BITS'(i_cfg.timeout)) begin
                n_latched = 1'b1;
                set_stall = 1'b1;
                o_stuck   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_latched <= 1'b0;
        end else if (i_update) begin
            r_started <= n_started;
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update && set_ref) begin
            r_ref_x    <= i_item.pos_x;
            r_ref_y    <= i_item.pos_y;
            r_ref_time <= i_item.time_ms;
        end
        if (i_update && set_stall) begin
            r_stall_x <= i_item.pos_x;
            r_stall_y <= i_item.pos_y;
        end
    end

    a_latched_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |-> r_started)
        else $error("stall latched without tracking started");

    a_stuck_keeps_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_update && o_stuck) |=> r_latched)
        else $error("stuck reported but latch not held");

    a_halt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_update && i_item.operation == OP_HALT) |=> (!r_started && !r_latched))
        else $error("halt did not clear tracking");

endmodule

`default_nettype wire

// File: design/motion_stall_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Motion stall detector. Each transfer on the input channel carries one position
// sample or a halt and yields exactly one stuck flag on the output channel, in
// order. A new item is taken every clock while the output is not stalled. An item
// goes into the input register at the edge that takes it and moves into the result
// register when that register is free or its flag is being taken; the distance and
// timeout check sits between those two registers. The three configuration
// registers are written through a port that is always ready and should only be
// written while no item is in flight.
module motion_stall_detector (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [msd_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [msd_pkg::CFG_DAT_BITS-1:0]      i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_operation,
    input  wire logic                                  i_pose_valid,
    input  wire logic signed [msd_pkg::COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [msd_pkg::COORD_BITS-1:0] i_pos_y,
    input  wire logic [msd_pkg::TIME_BITS-1:0]         i_time_ms,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic                                       o_stuck
);
    import msd_pkg::*;

    t_cfg  cfg;
    t_item r_item;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  r_stuck;
    logic  advance;
    logic  in_take;
    logic  stuck;

    msd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The held item moves into the result register when that register is free
    // or its content is being taken in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    msd_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_stuck  (stuck)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.operation  <= i_operation;
            r_item.pose_valid <= i_pose_valid;
            r_item.pos_x      <= i_pos_x;
            r_item.pos_y      <= i_pos_y;
            r_item.time_ms    <= i_time_ms;
        end
        if (advance) begin
            r_stuck <= stuck;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_stuck     = r_stuck;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after an item moved in");

    a_held_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_stuck)))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire
